// File: hw/rtl/flash_page_map_greedy_gc_assert.svh
// Assertion helpers for the RTL of the flash page map controller (fpm_ctrl).
`ifndef FLASH_PAGE_MAP_GREEDY_GC_ASSERT_SVH
`define FLASH_PAGE_MAP_GREEDY_GC_ASSERT_SVH

// Condition and consequence in the same cycle.
`define FPM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define FPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fpm_pkg.sv
// ============================================================================
// fpm_pkg
// Types and codes shared by the flash page map controller.
// ============================================================================
package fpm_pkg;

    typedef struct packed {
        logic       req_type;
        logic [7:0] lba;
    } req_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] src_block;
        logic [3:0] src_page;
        logic [3:0] dst_block;
        logic [3:0] dst_page;
        logic [7:0] moved_lba;
        logic       last;
    } rsp_t;

    localparam logic       REQ_READ     = 1'b0;
    localparam logic       REQ_WRITE    = 1'b1;

    localparam logic [2:0] CMD_READ     = 3'd0;
    localparam logic [2:0] CMD_UNMAPPED = 3'd1;
    localparam logic [2:0] CMD_PROGRAM  = 3'd2;
    localparam logic [2:0] CMD_COPY     = 3'd3;
    localparam logic [2:0] CMD_ERASE    = 3'd4;
    localparam logic [2:0] CMD_FAIL     = 3'd5;

    localparam logic [1:0] PG_FREE      = 2'd0;
    localparam logic [1:0] PG_USED      = 2'd1;
    localparam logic [1:0] PG_STALE     = 2'd2;

    localparam int         MAP_DEPTH    = 256;

endpackage

// File: hw/rtl/fpm_ram.sv
// ============================================================================
// fpm_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ============================================================================
module fpm_ram #(
    parameter int WIDTH = 8,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [2**AW];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/fpm_ctrl.sv
// ============================================================================
// fpm_ctrl
// Sequencer of the page map: lookups, stale marking, free-page search,
// greedy victim choice, copy and erase, with the result register.
// ============================================================================
`include "flash_page_map_greedy_gc_assert.svh"

module fpm_ctrl #(
    parameter int PHYS_BLOCKS     = 16,
    parameter int PAGES_PER_BLOCK = 16,
    parameter int LOGICAL_BLOCKS  = 12,
    parameter int SPARE_BLOCKS    = 1,
    parameter int BLK_W           = 4,
    parameter int PG_W            = 4,
    parameter int FILL_W          = 5
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  fpm_pkg::req_t            req,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output fpm_pkg::rsp_t            rsp,
    output logic                     map_we,
    output logic [7:0]               map_waddr,
    output logic [BLK_W+PG_W:0]      map_wdata,
    output logic                     map_re,
    output logic [7:0]               map_raddr,
    input  logic [BLK_W+PG_W:0]      map_rdata,
    output logic                     pg_we,
    output logic [BLK_W+PG_W-1:0]    pg_waddr,
    output logic [9:0]               pg_wdata,
    output logic                     pg_re,
    output logic [BLK_W+PG_W-1:0]    pg_raddr,
    input  logic [9:0]               pg_rdata,
    output logic                     bk_we,
    output logic [BLK_W-1:0]         bk_waddr,
    output logic [2*FILL_W-1:0]      bk_wdata,
    output logic                     bk_re,
    output logic [BLK_W-1:0]         bk_raddr,
    input  logic [2*FILL_W-1:0]      bk_rdata
);
    import fpm_pkg::*;

    localparam int          PA_W      = BLK_W + PG_W;
    localparam int          SP_W      = (SPARE_BLOCKS > 1) ? $clog2(SPARE_BLOCKS) : 1;
    localparam int unsigned LOG_PAGES = LOGICAL_BLOCKS * PAGES_PER_BLOCK;
    localparam logic [FILL_W-1:0] PPB_F = FILL_W'(PAGES_PER_BLOCK);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MAPRD, S_STALE, S_SRD, S_SCHK, S_PROG,
        S_GCSTART, S_DRD, S_CRD, S_CCHK, S_ERASE, S_ERASE2, S_FAILW, S_FAIL
    } state_t;

    state_t              state_reg, state_next;
    logic [7:0]          clr_reg;
    logic                type_reg, type_next;
    logic [7:0]          lba_reg, lba_next;
    logic [BLK_W-1:0]    scan_reg, scan_next;
    logic [BLK_W-1:0]    vict_reg, vict_next;
    logic                vict_ok_reg, vict_ok_next;
    logic [FILL_W-1:0]   best_reg, best_next;
    logic [BLK_W-1:0]    dst_reg, dst_next;
    logic [FILL_W-1:0]   dfill_reg, dfill_next;
    logic [FILL_W-1:0]   dstale_reg, dstale_next;
    logic [PG_W-1:0]     copy_reg, copy_next;
    logic [BLK_W-1:0]    pblk_reg, pblk_next;
    logic [FILL_W-1:0]   pfill_reg, pfill_next;
    logic [FILL_W-1:0]   pstale_reg, pstale_next;
    logic [SP_W-1:0]     ptr_reg;
    logic [BLK_W-1:0]    spare_blk_reg [SPARE_BLOCKS];
    logic                spare_ok_reg  [SPARE_BLOCKS];
    logic                rsp_valid_reg;
    rsp_t                rsp_reg, rsp_next;

    logic                emit;
    logic                can_emit;
    logic                spare_wr;
    logic                scan_spare;
    logic [FILL_W-1:0]   bk_fill;
    logic [FILL_W-1:0]   bk_stale;
    logic                lba_ok;
    logic [7:0]          own;

    function automatic rsp_t mk_rsp(logic [2:0] c, logic [3:0] sb, logic [3:0] sp,
                                    logic [3:0] db, logic [3:0] dp, logic [7:0] l,
                                    logic lst);
        rsp_t r;
        r.cmd       = c;
        r.src_block = sb;
        r.src_page  = sp;
        r.dst_block = db;
        r.dst_page  = dp;
        r.moved_lba = l;
        r.last      = lst;
        return r;
    endfunction

    assign can_emit  = !rsp_valid_reg || !rsp_stall;
    assign bk_fill   = bk_rdata[2*FILL_W-1:FILL_W];
    assign bk_stale  = bk_rdata[FILL_W-1:0];
    assign lba_ok    = 32'(req.lba) < LOG_PAGES;
    assign own       = pg_rdata[7:0];
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        scan_spare = 1'b0;
        for (int i = 0; i < SPARE_BLOCKS; i++)
        begin
            if (spare_ok_reg[i] && spare_blk_reg[i] == scan_reg)
            begin
                scan_spare = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        type_next    = type_reg;
        lba_next     = lba_reg;
        scan_next    = scan_reg;
        vict_next    = vict_reg;
        vict_ok_next = vict_ok_reg;
        best_next    = best_reg;
        dst_next     = dst_reg;
        dfill_next   = dfill_reg;
        dstale_next  = dstale_reg;
        copy_next    = copy_reg;
        pblk_next    = pblk_reg;
        pfill_next   = pfill_reg;
        pstale_next  = pstale_reg;
        rsp_next     = rsp_reg;
        emit         = 1'b0;
        spare_wr     = 1'b0;
        map_we       = 1'b0;
        map_waddr    = lba_reg;
        map_wdata    = '0;
        map_re       = 1'b0;
        map_raddr    = req.lba;
        pg_we        = 1'b0;
        pg_waddr     = '0;
        pg_wdata     = '0;
        pg_re        = 1'b0;
        pg_raddr     = {vict_reg, copy_reg};
        bk_we        = 1'b0;
        bk_waddr     = '0;
        bk_wdata     = '0;
        bk_re        = 1'b0;
        bk_raddr     = scan_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                bk_we     = 1'b1;
                bk_waddr  = clr_reg[BLK_W-1:0];
                if (clr_reg == 8'hFF)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    type_next = req.req_type;
                    lba_next  = req.lba;
                    if (!lba_ok)
                    begin
                        state_next = S_FAIL;
                    end
                    else
                    begin
                        map_re     = 1'b1;
                        state_next = S_MAPRD;
                    end
                end
            end
            S_MAPRD:
            begin
                if (type_reg == REQ_READ)
                begin
                    if (can_emit)
                    begin
                        emit = 1'b1;
                        if (map_rdata[PA_W])
                        begin
                            rsp_next = mk_rsp(CMD_READ, 4'(map_rdata[PA_W-1:PG_W]),
                                              4'(map_rdata[PG_W-1:0]), 4'd0, 4'd0,
                                              lba_reg, 1'b1);
                        end
                        else
                        begin
                            rsp_next = mk_rsp(CMD_UNMAPPED, 4'd0, 4'd0, 4'd0, 4'd0,
                                              lba_reg, 1'b1);
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    scan_next    = '0;
                    vict_ok_next = 1'b0;
                    best_next    = '0;
                    if (map_rdata[PA_W])
                    begin
                        // The old copy goes stale and the mapping is dropped.
                        map_we     = 1'b1;
                        pg_we      = 1'b1;
                        pg_waddr   = map_rdata[PA_W-1:0];
                        pg_wdata   = {PG_STALE, 8'd0};
                        bk_re      = 1'b1;
                        bk_raddr   = map_rdata[PA_W-1:PG_W];
                        state_next = S_STALE;
                    end
                    else
                    begin
                        state_next = S_SRD;
                    end
                end
            end
            S_STALE:
            begin
                bk_we      = 1'b1;
                bk_waddr   = map_rdata[PA_W-1:PG_W];
                bk_wdata   = {bk_fill, bk_stale + 1'b1};
                state_next = S_SRD;
            end
            S_SRD:
            begin
                bk_re      = 1'b1;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (!scan_spare && bk_fill < PPB_F)
                begin
                    pblk_next   = scan_reg;
                    pfill_next  = bk_fill;
                    pstale_next = bk_stale;
                    state_next  = S_PROG;
                end
                else
                begin
                    // Greedy victim: most stale pages, the later block on a tie.
                    if (!scan_spare && (!vict_ok_reg || bk_stale >= best_reg))
                    begin
                        best_next    = bk_stale;
                        vict_next    = scan_reg;
                        vict_ok_next = 1'b1;
                    end
                    if (scan_reg == BLK_W'(PHYS_BLOCKS - 1))
                    begin
                        state_next = S_GCSTART;
                    end
                    else
                    begin
                        scan_next  = scan_reg + 1'b1;
                        state_next = S_SRD;
                    end
                end
            end
            S_PROG:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    pg_we      = 1'b1;
                    pg_waddr   = {pblk_reg, pfill_reg[PG_W-1:0]};
                    pg_wdata   = {PG_USED, lba_reg};
                    map_we     = 1'b1;
                    map_wdata  = {1'b1, pblk_reg, pfill_reg[PG_W-1:0]};
                    bk_we      = 1'b1;
                    bk_waddr   = pblk_reg;
                    bk_wdata   = {pfill_reg + 1'b1, pstale_reg};
                    rsp_next   = mk_rsp(CMD_PROGRAM, 4'd0, 4'd0, 4'(pblk_reg),
                                        4'(pfill_reg[PG_W-1:0]), lba_reg, 1'b1);
                    state_next = S_IDLE;
                end
            end
            S_GCSTART:
            begin
                dst_next = spare_blk_reg[ptr_reg];
                if (!vict_ok_reg || !spare_ok_reg[ptr_reg])
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    bk_re      = 1'b1;
                    bk_raddr   = spare_blk_reg[ptr_reg];
                    state_next = S_DRD;
                end
            end
            S_DRD:
            begin
                dfill_next  = bk_fill;
                dstale_next = bk_stale;
                copy_next   = '0;
                state_next  = S_CRD;
            end
            S_CRD:
            begin
                pg_re      = 1'b1;
                state_next = S_CCHK;
            end
            S_CCHK:
            begin
                if (pg_rdata[9:8] == PG_USED)
                begin
                    if (dfill_reg == PPB_F)
                    begin
                        state_next = S_FAILW;
                    end
                    else if (can_emit)
                    begin
                        emit       = 1'b1;
                        pg_we      = 1'b1;
                        pg_waddr   = {dst_reg, dfill_reg[PG_W-1:0]};
                        pg_wdata   = {PG_USED, own};
                        map_we     = 32'(own) < LOG_PAGES;
                        map_waddr  = own;
                        map_wdata  = {1'b1, dst_reg, dfill_reg[PG_W-1:0]};
                        dfill_next = dfill_reg + 1'b1;
                        rsp_next   = mk_rsp(CMD_COPY, 4'(vict_reg), 4'(copy_reg),
                                            4'(dst_reg), 4'(dfill_reg[PG_W-1:0]),
                                            own, 1'b0);
                        copy_next  = copy_reg + 1'b1;
                        state_next = (copy_reg == PG_W'(PAGES_PER_BLOCK - 1)) ?
                                     S_ERASE : S_CRD;
                    end
                end
                else
                begin
                    copy_next  = copy_reg + 1'b1;
                    state_next = (copy_reg == PG_W'(PAGES_PER_BLOCK - 1)) ?
                                 S_ERASE : S_CRD;
                end
            end
            S_ERASE:
            begin
                bk_we      = 1'b1;
                bk_waddr   = dst_reg;
                bk_wdata   = {dfill_reg, dstale_reg};
                state_next = S_ERASE2;
            end
            S_ERASE2:
            begin
                if (can_emit)
                begin
                    emit     = 1'b1;
                    spare_wr = 1'b1;
                    bk_we    = 1'b1;
                    bk_waddr = vict_reg;
                    rsp_next = mk_rsp(CMD_ERASE, 4'(vict_reg), 4'd0, 4'd0, 4'd0,
                                      8'd0, 1'b0);
                    // Every other block was full, so only the old spare can take it.
                    pblk_next   = dst_reg;
                    pfill_next  = dfill_reg;
                    pstale_next = dstale_reg;
                    state_next  = (dfill_reg < PPB_F) ? S_PROG : S_FAIL;
                end
            end
            S_FAILW:
            begin
                bk_we      = 1'b1;
                bk_waddr   = dst_reg;
                bk_wdata   = {dfill_reg, dstale_reg};
                state_next = S_FAIL;
            end
            S_FAIL:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    rsp_next   = mk_rsp(CMD_FAIL, 4'd0, 4'd0, 4'd0, 4'd0, 8'd0, 1'b1);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < SPARE_BLOCKS; i++)
            begin
                spare_blk_reg[i] <= BLK_W'(PHYS_BLOCKS - SPARE_BLOCKS + i);
                spare_ok_reg[i]  <= (PHYS_BLOCKS - SPARE_BLOCKS + i) >= 0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_reg + 1'b1;
            rsp_valid_reg <= emit || (rsp_valid_reg && rsp_stall);
            if (spare_wr)
            begin
                spare_blk_reg[ptr_reg] <= vict_reg;
                spare_ok_reg[ptr_reg]  <= 1'b1;
                ptr_reg <= (ptr_reg == SP_W'(SPARE_BLOCKS - 1)) ? '0 : ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg    <= type_next;
        lba_reg     <= lba_next;
        scan_reg    <= scan_next;
        vict_reg    <= vict_next;
        vict_ok_reg <= vict_ok_next;
        best_reg    <= best_next;
        dst_reg     <= dst_next;
        dfill_reg   <= dfill_next;
        dstale_reg  <= dstale_next;
        copy_reg    <= copy_next;
        pblk_reg    <= pblk_next;
        pfill_reg   <= pfill_next;
        pstale_reg  <= pstale_next;
        rsp_reg     <= rsp_next;
    end

    `FPM_ASSERT_NOW(a_nonlast_kind, clk, rst_n, rsp_valid_reg && !rsp_reg.last,
        rsp_reg.cmd == CMD_COPY || rsp_reg.cmd == CMD_ERASE,
        "only copy and erase beats may precede the final beat")
    `FPM_ASSERT_NEXT(a_one_request, clk, rst_n, req_valid && !req_stall,
        req_stall, "a second request was taken while one was in flight")
    `FPM_ASSERT_NOW(a_dst_fill, clk, rst_n, state_reg == S_CCHK,
        dfill_reg <= PPB_F, "spare block fill count ran past the block size")
    `FPM_ASSERT_NOW(a_emit_room, clk, rst_n, emit,
        !rsp_valid_reg || !rsp_stall, "result beat written over a stalled beat")

endmodule

// File: hw/rtl/flash_page_map_greedy_gc.sv
// ============================================================================
// flash_page_map_greedy_gc
// Page-mapped flash translation controller with greedy garbage collection.
// ============================================================================
// Requests arrive on req (valid/stall), one logical page per beat. Each
// request gives one or more result beats on rsp (valid/stall); the final
// beat of a request carries last. A read puts its beat in the output
// register once that register has room. A write scans the block table,
// reading and checking one block after another until a block with room
// turns up, and first marks an old copy stale when there is one. When no
// room is left, the scan covers every block and collection follows: each
// victim page is read and checked, each used page is copied to the spare
// with a copy beat, then come the erase beat and the program beat (or a
// fail beat when the spare block fills up).
// One request is in flight at a time; req_stall stays high until its last
// beat is in the output register. A stalled result beat holds, and the
// controller waits on it before writing the next.
// After reset a clearing pass over all 256 map entries empties the page
// map and the block table; requests are held off until it ends.
// ============================================================================
module flash_page_map_greedy_gc #(
    parameter int PHYS_BLOCKS     = 16,
    parameter int PAGES_PER_BLOCK = 16,
    parameter int LOGICAL_BLOCKS  = 12,
    parameter int SPARE_BLOCKS    = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  fpm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output fpm_pkg::rsp_t rsp
);
    import fpm_pkg::*;

    localparam int BLK_W  = $clog2(PHYS_BLOCKS);
    localparam int PG_W   = $clog2(PAGES_PER_BLOCK);
    localparam int FILL_W = $clog2(PAGES_PER_BLOCK + 1);
    localparam int PA_W   = BLK_W + PG_W;
    localparam int MAP_AW = $clog2(MAP_DEPTH);

    logic                map_we, map_re;
    logic [MAP_AW-1:0]   map_waddr, map_raddr;
    logic [PA_W:0]       map_wdata, map_rdata;
    logic                pg_we, pg_re;
    logic [PA_W-1:0]     pg_waddr, pg_raddr;
    logic [9:0]          pg_wdata, pg_rdata;
    logic                bk_we, bk_re;
    logic [BLK_W-1:0]    bk_waddr, bk_raddr;
    logic [2*FILL_W-1:0] bk_wdata, bk_rdata;

    // Logical map: valid bit, block and page of each logical page.
    fpm_ram #(.WIDTH(PA_W + 1), .AW(MAP_AW)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    // Physical pages: status and owning logical page.
    fpm_ram #(.WIDTH(10), .AW(PA_W)) u_page_ram (
        .clk   (clk),
        .we    (pg_we),
        .waddr (pg_waddr),
        .wdata (pg_wdata),
        .re    (pg_re),
        .raddr (pg_raddr),
        .rdata (pg_rdata)
    );

    // Blocks: fill count (pages at or past it are free) and stale count.
    fpm_ram #(.WIDTH(2 * FILL_W), .AW(BLK_W)) u_blk_ram (
        .clk   (clk),
        .we    (bk_we),
        .waddr (bk_waddr),
        .wdata (bk_wdata),
        .re    (bk_re),
        .raddr (bk_raddr),
        .rdata (bk_rdata)
    );

    fpm_ctrl #(
        .PHYS_BLOCKS     (PHYS_BLOCKS),
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK),
        .LOGICAL_BLOCKS  (LOGICAL_BLOCKS),
        .SPARE_BLOCKS    (SPARE_BLOCKS),
        .BLK_W           (BLK_W),
        .PG_W            (PG_W),
        .FILL_W          (FILL_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .map_we    (map_we),
        .map_waddr (map_waddr),
        .map_wdata (map_wdata),
        .map_re    (map_re),
        .map_raddr (map_raddr),
        .map_rdata (map_rdata),
        .pg_we     (pg_we),
        .pg_waddr  (pg_waddr),
        .pg_wdata  (pg_wdata),
        .pg_re     (pg_re),
        .pg_raddr  (pg_raddr),
        .pg_rdata  (pg_rdata),
        .bk_we     (bk_we),
        .bk_waddr  (bk_waddr),
        .bk_wdata  (bk_wdata),
        .bk_re     (bk_re),
        .bk_raddr  (bk_raddr),
        .bk_rdata  (bk_rdata)
    );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Flash page map controller testbench
// Runs a table of directed requests, then random reads and writes, the
// writes mostly over a hot subset of logical pages, out-of-range noise mixed
// in. Each beat is checked field by field against the bench mapping model.
// ============================================================================
module tb;
    import fpm_pkg::*;

    localparam int NBLK  = 16;
    localparam int NPG   = 16;
    localparam int NLOG  = 12 * NPG;
    localparam int NPHYS = NBLK * NPG;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_stall;
    rsp_t  rsp;

    flash_page_map_greedy_gc u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Mapping state mirrored from the block.
    logic        lmap_ok [NLOG];
    int          lmap    [NLOG];
    logic        owner_ok[NPHYS];
    int          owner   [NPHYS];
    logic [1:0]  pstat   [NPHYS];
    int          stale   [NBLK];
    int          spare;

    rsp_t expected_beats[$];
    int   errors;
    int   n_beats;
    int   n_gc;
    logic stim_done;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    initial
    begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int short_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(5, 30);
        else if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    task automatic push_beat(logic [2:0] c, int sb, int sp, int db, int dp,
                             int l, logic lst);
        rsp_t r;
        r.cmd       = c;
        r.src_block = sb[3:0];
        r.src_page  = sp[3:0];
        r.dst_block = db[3:0];
        r.dst_page  = dp[3:0];
        r.moved_lba = l[7:0];
        r.last      = lst;
        expected_beats.push_back(r);
    endtask

    function automatic int find_free();
        for (int b = 0; b < NBLK; b++)
        begin
            if (b == spare)
                continue;
            for (int p = 0; p < NPG; p++)
                if (pstat[b * NPG + p] == PG_FREE)
                    return b * NPG + p;
        end
        return -1;
    endfunction

    task automatic flash_reset();
        for (int i = 0; i < NLOG; i++)
        begin
            lmap_ok[i] = 1'b0;
            lmap[i]    = 0;
        end
        for (int i = 0; i < NPHYS; i++)
        begin
            owner_ok[i] = 1'b0;
            owner[i]    = 0;
            pstat[i]    = PG_FREE;
        end
        for (int i = 0; i < NBLK; i++)
            stale[i] = 0;
        spare = NBLK - 1;
    endtask

    // Expected beats of one request, with state update.
    task automatic predict_request(req_t r);
        int f;
        int victim;
        int best;
        int d;
        int a;
        int l;
        l = int'(r.lba);
        if (l >= NLOG)
        begin
            push_beat(CMD_FAIL, 0, 0, 0, 0, 0, 1'b1);
            return;
        end
        if (r.req_type == REQ_READ)
        begin
            if (lmap_ok[l])
                push_beat(CMD_READ, lmap[l] / NPG, lmap[l] % NPG, 0, 0, l, 1'b1);
            else
                push_beat(CMD_UNMAPPED, 0, 0, 0, 0, l, 1'b1);
            return;
        end
        if (lmap_ok[l])
        begin
            a = lmap[l];
            if (pstat[a] == PG_USED)
            begin
                pstat[a] = PG_STALE;
                stale[a / NPG]++;
            end
            owner_ok[a] = 1'b0;
            owner[a]    = 0;
            lmap_ok[l]  = 1'b0;
            lmap[l]     = 0;
        end
        f = find_free();
        if (f < 0)
        begin
            n_gc++;
            victim = -1;
            best   = 0;
            for (int b = 0; b < NBLK; b++)
            begin
                if (b == spare)
                    continue;
                if (victim < 0 || stale[b] >= best)
                begin
                    best   = stale[b];
                    victim = b;
                end
            end
            for (int p = 0; p < NPG; p++)
            begin
                a = victim * NPG + p;
                if (pstat[a] != PG_USED)
                    continue;
                d = -1;
                for (int q = 0; q < NPG; q++)
                    if (d < 0 && pstat[spare * NPG + q] == PG_FREE)
                        d = spare * NPG + q;
                if (d < 0)
                begin
                    push_beat(CMD_FAIL, 0, 0, 0, 0, 0, 1'b1);
                    return;
                end
                pstat[d]    = PG_USED;
                owner_ok[d] = owner_ok[a];
                owner[d]    = owner_ok[a] ? owner[a] : 0;
                if (owner_ok[a] && owner[a] < NLOG)
                    lmap[owner[a]] = d;
                push_beat(CMD_COPY, victim, p, d / NPG, d % NPG, owner[d], 1'b0);
            end
            for (int p = 0; p < NPG; p++)
            begin
                a = victim * NPG + p;
                pstat[a]    = PG_FREE;
                owner_ok[a] = 1'b0;
                owner[a]    = 0;
            end
            stale[victim] = 0;
            push_beat(CMD_ERASE, victim, 0, 0, 0, 0, 1'b0);
            spare = victim;
            f = find_free();
            if (f < 0)
            begin
                push_beat(CMD_FAIL, 0, 0, 0, 0, 0, 1'b1);
                return;
            end
        end
        pstat[f]    = PG_USED;
        owner_ok[f] = 1'b1;
        owner[f]    = l;
        lmap_ok[l]  = 1'b1;
        lmap[l]     = f;
        push_beat(CMD_PROGRAM, 0, 0, f / NPG, f % NPG, l, 1'b1);
    endtask

    // Valid stays high from one beat to the next when there is no gap.
    task automatic send_request(logic t, int l);
        req_t r;
        int   g;
        r.req_type = t;
        r.lba      = l[7:0];
        g = short_gap();
        if (g != 0)
        begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        predict_request(r);
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Directed rows; a row whose expected cmd is typed in is checked for that
    // code on top of the predictor.
    typedef struct {
        logic       t;
        int         l;
        logic [2:0] want;
        logic       typed;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        '{REQ_READ,  0,   CMD_UNMAPPED, 1'b1},
        '{REQ_READ,  191, CMD_UNMAPPED, 1'b1},
        '{REQ_READ,  192, CMD_FAIL,     1'b1},
        '{REQ_WRITE, 255, CMD_FAIL,     1'b1},
        '{REQ_WRITE, 0,   CMD_PROGRAM,  1'b1},
        '{REQ_READ,  0,   CMD_READ,     1'b1},
        '{REQ_WRITE, 191, CMD_PROGRAM,  1'b1},
        '{REQ_WRITE, 0,   CMD_PROGRAM,  1'b1},
        '{REQ_READ,  0,   CMD_READ,     1'b0},
        '{REQ_READ,  170, CMD_UNMAPPED, 1'b1},
        '{REQ_WRITE, 85,  CMD_PROGRAM,  1'b0},
        '{REQ_READ,  85,  CMD_READ,     1'b0},
        '{REQ_READ,  128, CMD_UNMAPPED, 1'b0},
        '{REQ_WRITE, 127, CMD_PROGRAM,  1'b0}
    };

    initial
    begin
        int  k;
        int  lba_v;
        logic t;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        errors    = 0;
        n_beats   = 0;
        n_gc      = 0;
        stim_done = 1'b0;
        flash_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            k = expected_beats.size();
            send_request(dir_rows[i].t, dir_rows[i].l);
            if (dir_rows[i].typed && expected_beats[expected_beats.size() - 1].cmd
                != dir_rows[i].want)
            begin
                $error("row %0d: predictor cmd %0d, table cmd %0d", i,
                       expected_beats[expected_beats.size() - 1].cmd, dir_rows[i].want);
                errors++;
            end
        end

        // Mostly writes, most over a hot subset so that pages go stale; reads and
        // out-of-range noise mixed in.
        for (int i = 0; i < 146; i++)
        begin
            if (i == 73)
            begin
                req_valid <= 1'b0;
                while (expected_beats.size() != 0)
                    @(posedge clk);
            end
            k = $urandom_range(0, 99);
            if (k < 5)
            begin
                t     = 1'($urandom_range(0, 1));
                lba_v = $urandom_range(NLOG, 255);
            end
            else if (k < 25)
            begin
                t     = REQ_READ;
                lba_v = $urandom_range(0, NLOG - 1);
            end
            else if (k < 70)
            begin
                t     = REQ_WRITE;
                lba_v = $urandom_range(0, 31);
            end
            else
            begin
                t     = REQ_WRITE;
                lba_v = $urandom_range(0, NLOG - 1);
            end
            send_request(t, lba_v);
        end
        req_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Result side: random stalls, compare every accepted beat.
    initial
    begin
        rsp_t got;
        rsp_t want;
        int   g;
        rsp_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            g = short_gap();
            if (g != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (g) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            if (rsp_valid && !rsp_stall)
            begin
                got = rsp;
                n_beats++;
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected beat cmd %0d", got.cmd);
                    errors++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (got.cmd != want.cmd)
                    begin
                        $error("cmd: expected %0d, actual %0d", want.cmd, got.cmd);
                        errors++;
                    end
                    if (got.src_block != want.src_block)
                    begin
                        $error("src_block: expected %0d, actual %0d",
                               want.src_block, got.src_block);
                        errors++;
                    end
                    if (got.src_page != want.src_page)
                    begin
                        $error("src_page: expected %0d, actual %0d",
                               want.src_page, got.src_page);
                        errors++;
                    end
                    if (got.dst_block != want.dst_block)
                    begin
                        $error("dst_block: expected %0d, actual %0d",
                               want.dst_block, got.dst_block);
                        errors++;
                    end
                    if (got.dst_page != want.dst_page)
                    begin
                        $error("dst_page: expected %0d, actual %0d",
                               want.dst_page, got.dst_page);
                        errors++;
                    end
                    if (got.moved_lba != want.moved_lba)
                    begin
                        $error("moved_lba: expected %0d, actual %0d",
                               want.moved_lba, got.moved_lba);
                        errors++;
                    end
                    if (got.last != want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        wait (stim_done === 1'b1);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Checked %0d result beats; garbage collection ran %0d times.",
                 n_beats, n_gc);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
